FILE: design/bst_pkg.sv
// Shared types and constants for the bencode stream tokenizer.
// Used by bst_stack, bst_parser and bencode_stream_tokenizer; no dependencies.
package bst_pkg;

  // Parser modes
  typedef enum logic [2:0] {
    MODE_TOP    = 3'd0,
    MODE_ELEM   = 3'd1,
    MODE_SLEN   = 3'd2,
    MODE_SDATA  = 3'd3,
    MODE_ISTART = 3'd4,
    MODE_IDIG   = 3'd5,
    MODE_DONE   = 3'd6,
    MODE_ERR    = 3'd7
  } mode_t;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_DICT_OPEN = 3'd0,
    KIND_LIST_OPEN = 3'd1,
    KIND_CLOSE     = 3'd2,
    KIND_STR_BYTE  = 3'd3,
    KIND_STR_EMPTY = 3'd4,
    KIND_INTEGER   = 3'd5,
    KIND_ERROR     = 3'd6
  } kind_t;

  // Error codes
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_BYTE  = 3'd1,
    ERR_DEPTH     = 3'd2,
    ERR_LENGTH    = 3'd3,
    ERR_INTEGER   = 3'd4,
    ERR_NON_STR   = 3'd5,
    ERR_TRAILING  = 3'd6
  } err_t;

  // Container stack operations
  typedef enum logic [1:0] {
    STK_HOLD    = 2'd0,
    STK_PUSH    = 2'd1,
    STK_POP     = 2'd2,
    STK_ADVANCE = 2'd3
  } stk_op_t;

  typedef struct packed {
    stk_op_t op;
    logic    is_dict;
  } stk_cmd_t;

  typedef struct packed {
    logic is_dict;
    logic key_exp;
  } stk_top_t;

  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic [7:0]         payload_byte;
    logic signed [63:0] int_value;
    logic               is_key;
    logic [4:0]         nest_level;
    logic               last_byte;
    err_t               error_code;
  } res_t;

  // Stream characters
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // Integer magnitude limits, widened for the times-ten check
  localparam logic [67:0] POS_LIMIT = 68'h0_7FFF_FFFF_FFFF_FFFF;
  localparam logic [67:0] NEG_LIMIT = 68'h0_8000_0000_0000_0000;

endpackage

FILE: design/bencode_stream_tokenizer.sv
// Top level of the bencode stream tokenizer: input and result registers
// around the parser. Depends on bst_pkg and bst_parser.
//
// Usage:
//   Input channel (in_valid, in_ready, data_byte) carries one raw byte of a
//   bencoded stream per request; the top level must be a dictionary.
//   Output channel (out_valid, out_ready, kind, payload_byte, int_value,
//   is_key, nest_level, last_byte, error_code) carries at most one event
//   per input byte: container open/close, string byte, empty string,
//   finished integer, or a single error.
//   An accepted byte is held in the input register until the result
//   register can take its event; the event, if any, is then loaded into
//   the result register and out_valid rises.
//   Throughput: one byte per cycle while the result register is free or
//   out_ready is high; the mode, counters and stack top are updated in one
//   pass per byte and the next byte follows at once.
//   Reset (rst, synchronous) returns to waiting for the top dictionary with
//   an empty stack and clears both registers.
//   When the receiver stalls, the result register holds its event, the
//   input register holds one more byte, and in_ready drops until
//   out_ready returns. After an error event all later bytes are taken and
//   dropped until reset.
module bencode_stream_tokenizer #(
  parameter int MAX_DEPTH   = 16,
  parameter int LENGTH_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         kind,
  output logic [7:0]         payload_byte,
  output logic signed [63:0] int_value,
  output logic               is_key,
  output logic [4:0]         nest_level,
  output logic               last_byte,
  output logic [2:0]         error_code
);
  import bst_pkg::*;

  logic       in_full;
  logic [7:0] in_byte;
  logic       advance;
  logic       out_full;
  res_t       res;
  res_t       out_res;

  // Process the held byte when the result register can take its event
  assign advance  = in_full && (!out_full || out_ready);
  assign in_ready = !in_full || advance;

  bst_parser #(
    .MAX_DEPTH   (MAX_DEPTH),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_byte),
    .res       (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_byte <= data_byte;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance && res.valid) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) out_res <= res;
  end

  assign out_valid    = out_full;
  assign kind         = out_res.kind;
  assign payload_byte = out_res.payload_byte;
  assign int_value    = out_res.int_value;
  assign is_key       = out_res.is_key;
  assign nest_level   = out_res.nest_level;
  assign last_byte    = out_res.last_byte;
  assign error_code   = out_res.error_code;

  // A stalled byte stays in the input register
  assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full && $stable(in_byte))
    else $error("held input byte lost");

  // Error events always carry a code, other events never do
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_res.kind == KIND_ERROR) == (out_res.error_code != ERR_NONE)))
    else $error("error code does not match event kind");

endmodule

FILE: design/bst_stack.sv
// Shift stack of container kinds and dictionary key/value phases.
// Entry 0 is always the innermost container. Depends on bst_pkg.
module bst_stack #(
  parameter int MAX_DEPTH = 16
) (
  input  logic              clk,
  input  bst_pkg::stk_cmd_t cmd,
  output bst_pkg::stk_top_t top
);
  import bst_pkg::*;

  // One spare slot above the last entry keeps the shifts uniform
  logic [MAX_DEPTH:0] dict_q;
  logic [MAX_DEPTH:0] key_q;
  logic [MAX_DEPTH:0] dict_next;
  logic [MAX_DEPTH:0] key_next;
  logic [MAX_DEPTH:0] dict_up;
  logic [MAX_DEPTH:0] key_up;

  assign top.is_dict = dict_q[0];
  assign top.key_exp = key_q[0];

  // Compute next stack contents
  always_comb begin
    dict_up   = {1'b0, dict_q[MAX_DEPTH:1]};
    key_up    = {1'b0, key_q[MAX_DEPTH:1]};
    dict_next = dict_q;
    key_next  = key_q;
    case (cmd.op)
      STK_PUSH: begin
        dict_next = {dict_q[MAX_DEPTH-1:0], cmd.is_dict};
        key_next  = {key_q[MAX_DEPTH-1:0], cmd.is_dict};
      end
      STK_POP: begin
        // drop the top and flip the parent's phase if it is a dictionary
        dict_next   = dict_up;
        key_next    = key_up;
        key_next[0] = key_up[0] ^ dict_up[0];
      end
      STK_ADVANCE: begin
        key_next[0] = key_q[0] ^ dict_q[0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    dict_q <= dict_next;
    key_q  <= key_next;
  end

  // A pushed container shows its own kind on top next cycle
  assert property (@(posedge clk)
    cmd.op == STK_PUSH |=> top.is_dict == $past(cmd.is_dict)
                           && top.key_exp == $past(cmd.is_dict))
    else $error("stack push did not land on top");

endmodule

FILE: design/bst_parser.sv
// Byte-level bencode parser: mode register, length and integer
// accumulators, depth counter and result decode. Depends on bst_pkg, bst_stack.
module bst_parser #(
  parameter int MAX_DEPTH   = 16,
  parameter int LENGTH_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    data_byte,
  output bst_pkg::res_t res
);
  import bst_pkg::*;

  localparam int DW = $clog2(MAX_DEPTH + 1);

  mode_t                  mode, mode_next;
  logic [LENGTH_BITS-1:0] length_count, length_count_next;
  logic [63:0]            integer_accum, integer_accum_next;
  logic                   integer_negative, integer_negative_next;
  logic [DW-1:0]          current_depth, current_depth_next;
  logic                   string_is_key, string_is_key_next;

  stk_cmd_t cmd;
  stk_top_t top;
  err_t     err;

  logic                   is_digit;
  logic [3:0]             digit;
  logic                   want_key;
  logic                   depth_full;
  logic                   depth_zero;
  logic [DW-1:0]          depth_dec;
  logic [DW+4:0]          depth_ext;
  logic [DW+4:0]          depth_dec_ext;
  logic [LENGTH_BITS+3:0] len_wide;
  logic [LENGTH_BITS+3:0] len_times10;
  logic                   len_ovf;
  logic [67:0]            acc_wide;
  logic [67:0]            acc_times10;
  logic                   acc_ovf;
  logic [63:0]            int_signed;

  bst_stack #(.MAX_DEPTH(MAX_DEPTH)) u_stack (
    .clk (clk),
    .cmd (cmd),
    .top (top)
  );

  // Byte classes and arithmetic helpers
  assign is_digit      = (data_byte >= CH_0) && (data_byte <= CH_9);
  assign digit         = 4'(data_byte - CH_0);
  assign depth_zero    = (current_depth == '0);
  assign depth_full    = (current_depth >= DW'(MAX_DEPTH));
  assign want_key      = !depth_zero && top.is_dict && top.key_exp;
  assign depth_dec     = current_depth - 1'b1;
  assign depth_ext     = {5'b0, current_depth};
  assign depth_dec_ext = {5'b0, depth_dec};

  // Length times ten plus digit; overflow when any carry bit is set
  assign len_wide    = {4'b0, length_count};
  assign len_times10 = (len_wide << 3) + (len_wide << 1) + (LENGTH_BITS+4)'(digit);
  assign len_ovf     = (len_times10[LENGTH_BITS+3:LENGTH_BITS] != 4'b0);

  // Integer magnitude times ten plus digit, against the signed limit
  assign acc_wide    = {4'b0, integer_accum};
  assign acc_times10 = (acc_wide << 3) + (acc_wide << 1) + 68'(digit);
  assign acc_ovf     = acc_times10 > (integer_negative ? NEG_LIMIT : POS_LIMIT);
  assign int_signed  = integer_negative ? (64'd0 - integer_accum) : integer_accum;

  // Detect malformed input for the current mode
  always_comb begin
    err = ERR_NONE;
    unique case (mode)
      MODE_TOP: begin
        if (data_byte != CH_D) err = ERR_BAD_BYTE;
      end
      MODE_ELEM: begin
        if (data_byte == CH_E) begin
          if (depth_zero || (top.is_dict && !top.key_exp)) err = ERR_BAD_BYTE;
        end else if (data_byte == CH_I || data_byte == CH_L || data_byte == CH_D) begin
          if (want_key) err = ERR_NON_STR;
          else if (data_byte != CH_I && depth_full) err = ERR_DEPTH;
        end else if (!is_digit) begin
          err = ERR_BAD_BYTE;
        end
      end
      MODE_SLEN: begin
        if (is_digit) begin
          if (len_ovf) err = ERR_LENGTH;
        end else if (data_byte != CH_COLON) begin
          err = ERR_BAD_BYTE;
        end
      end
      MODE_SDATA: begin
      end
      MODE_ISTART: begin
        if (!(data_byte == CH_MINUS && !integer_negative) && !is_digit) err = ERR_BAD_BYTE;
      end
      MODE_IDIG: begin
        if (is_digit) begin
          if (acc_ovf) err = ERR_INTEGER;
        end else if (data_byte != CH_E) begin
          err = ERR_BAD_BYTE;
        end
      end
      MODE_DONE: err = ERR_TRAILING;
      MODE_ERR: begin
      end
      default: begin
      end
    endcase
  end

  // Next mode
  always_comb begin
    mode_next = mode;
    if (err != ERR_NONE) begin
      mode_next = MODE_ERR;
    end else begin
      unique case (mode)
        MODE_TOP: mode_next = MODE_ELEM;
        MODE_ELEM: begin
          if (data_byte == CH_E)
            mode_next = (current_depth == DW'(1)) ? MODE_DONE : MODE_ELEM;
          else if (is_digit)        mode_next = MODE_SLEN;
          else if (data_byte == CH_I) mode_next = MODE_ISTART;
          else                      mode_next = MODE_ELEM;
        end
        MODE_SLEN: begin
          if (data_byte == CH_COLON)
            mode_next = (length_count == '0) ? MODE_ELEM : MODE_SDATA;
        end
        MODE_SDATA: begin
          if (length_count <= LENGTH_BITS'(1)) mode_next = MODE_ELEM;
        end
        MODE_ISTART: begin
          if (is_digit) mode_next = MODE_IDIG;
        end
        MODE_IDIG: begin
          if (data_byte == CH_E) mode_next = MODE_ELEM;
        end
        MODE_DONE: mode_next = MODE_ERR;
        MODE_ERR:  mode_next = MODE_ERR;
        default:   mode_next = MODE_ERR;
      endcase
    end
  end

  // Result, stack command and datapath updates
  always_comb begin
    res                   = '0;
    cmd.op                = STK_HOLD;
    cmd.is_dict           = (data_byte == CH_D);
    length_count_next     = length_count;
    integer_accum_next    = integer_accum;
    integer_negative_next = integer_negative;
    current_depth_next    = current_depth;
    string_is_key_next    = string_is_key;
    if (err != ERR_NONE) begin
      res.valid      = 1'b1;
      res.kind       = KIND_ERROR;
      res.nest_level = depth_ext[4:0];
      res.error_code = err;
    end else begin
      unique case (mode)
        MODE_TOP, MODE_ELEM: begin
          if (mode == MODE_ELEM && data_byte == CH_E) begin
            // close the innermost container
            cmd.op             = STK_POP;
            current_depth_next = depth_dec;
            res.valid          = 1'b1;
            res.kind           = KIND_CLOSE;
            res.nest_level     = depth_dec_ext[4:0];
          end else if (mode == MODE_ELEM && is_digit) begin
            string_is_key_next = want_key;
            length_count_next  = LENGTH_BITS'(digit);
          end else if (mode == MODE_ELEM && data_byte == CH_I) begin
            integer_accum_next    = '0;
            integer_negative_next = 1'b0;
          end else begin
            // open a dictionary or a list
            cmd.op             = STK_PUSH;
            current_depth_next = current_depth + 1'b1;
            res.valid          = 1'b1;
            res.kind           = (data_byte == CH_D) ? KIND_DICT_OPEN : KIND_LIST_OPEN;
            res.nest_level     = depth_ext[4:0];
          end
        end
        MODE_SLEN: begin
          if (is_digit) begin
            length_count_next = len_times10[LENGTH_BITS-1:0];
          end else if (length_count == '0) begin
            cmd.op         = STK_ADVANCE;
            res.valid      = 1'b1;
            res.kind       = KIND_STR_EMPTY;
            res.is_key     = string_is_key;
            res.nest_level = depth_ext[4:0];
          end
        end
        MODE_SDATA: begin
          res.valid        = 1'b1;
          res.kind         = KIND_STR_BYTE;
          res.payload_byte = data_byte;
          res.is_key       = string_is_key;
          res.nest_level   = depth_ext[4:0];
          if (length_count <= LENGTH_BITS'(1)) begin
            res.last_byte     = 1'b1;
            length_count_next = '0;
            cmd.op            = STK_ADVANCE;
          end else begin
            length_count_next = length_count - 1'b1;
          end
        end
        MODE_ISTART: begin
          if (is_digit) integer_accum_next = 64'(digit);
          else          integer_negative_next = 1'b1;
        end
        MODE_IDIG: begin
          if (is_digit) begin
            integer_accum_next = acc_times10[63:0];
          end else begin
            cmd.op         = STK_ADVANCE;
            res.valid      = 1'b1;
            res.kind       = KIND_INTEGER;
            res.int_value  = int_signed;
            res.nest_level = depth_ext[4:0];
          end
        end
        MODE_DONE, MODE_ERR: begin
        end
        default: begin
        end
      endcase
    end
    // hold everything when no byte is processed
    if (!step) begin
      res.valid             = 1'b0;
      cmd.op                = STK_HOLD;
      length_count_next     = length_count;
      integer_accum_next    = integer_accum;
      integer_negative_next = integer_negative;
      current_depth_next    = current_depth;
      string_is_key_next    = string_is_key;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_TOP;
      length_count     <= '0;
      integer_accum    <= '0;
      integer_negative <= 1'b0;
      current_depth    <= '0;
      string_is_key    <= 1'b0;
    end else begin
      if (step) mode <= mode_next;
      length_count     <= length_count_next;
      integer_accum    <= integer_accum_next;
      integer_negative <= integer_negative_next;
      current_depth    <= current_depth_next;
      string_is_key    <= string_is_key_next;
    end
  end

  // Depth stays within the stack
  assert property (@(posedge clk) disable iff (rst)
    current_depth <= DW'(MAX_DEPTH))
    else $error("container depth beyond stack size");

  // After an error no further result is produced
  assert property (@(posedge clk) disable iff (rst)
    mode == MODE_ERR |-> !res.valid)
    else $error("result produced after sticky error");

  // Finished top dictionary means an empty stack
  assert property (@(posedge clk) disable iff (rst)
    mode == MODE_DONE |-> depth_zero)
    else $error("done with containers still open");

endmodule
